// ===== rtl/core/chul_pkg.sv =====
// chul_pkg: types, constants and helpers for the convex hull unit
// used by chul_cross and convex_hull_monotone_chain_unit; depends on nothing
package chul_pkg;

  localparam int MAX_POINTS = 32;
  localparam int COORD_BITS = 16;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int STK_DEPTH = 2 * MAX_POINTS;
  localparam int STK_AW = $clog2(STK_DEPTH);
  localparam int TOP_W = $clog2(STK_DEPTH + 1);
  localparam int PT_W = 2 * COORD_BITS;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } point_t;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               last_point;
  } in_t;

  typedef struct packed {
    logic signed [15:0] hull_x;
    logic signed [15:0] hull_y;
    logic               is_last;
    logic [5:0]         vertex_count;
    logic               points_dropped;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_H_RD,
    S_H_RDB,
    S_H_CHK,
    S_H_MUL,
    S_H_CMP,
    S_H_RDS,
    S_H_RDO,
    S_E_RS,
    S_E_RP,
    S_E_OUT
  } state_t;

  // strict (x, then y) order
  function automatic logic precedes(input point_t a, input point_t b);
    precedes = (a.x < b.x) || ((a.x == b.x) && (a.y < b.y));
  endfunction

endpackage

// ===== rtl/core/chul_ram.sv =====
// chul_ram: generic one-write one-read memory with registered read data
// depends on nothing
module chul_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/chul_cross.sv =====
// chul_cross: registered exact cross product and turn test
// depends on chul_pkg
module chul_cross (
  input  logic            clk,
  input  chul_pkg::point_t o,
  input  chul_pkg::point_t a,
  input  chul_pkg::point_t b,
  output logic            not_left
);

  localparam int DW = chul_pkg::COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] dax, day, dbx, dby;
  logic signed [PW-1:0] p1_r, p2_r;
  logic signed [PW:0]   diff;

  assign dax = {a.x[chul_pkg::COORD_BITS-1], a.x} - {o.x[chul_pkg::COORD_BITS-1], o.x};
  assign day = {a.y[chul_pkg::COORD_BITS-1], a.y} - {o.y[chul_pkg::COORD_BITS-1], o.y};
  assign dbx = {b.x[chul_pkg::COORD_BITS-1], b.x} - {o.x[chul_pkg::COORD_BITS-1], o.x};
  assign dby = {b.y[chul_pkg::COORD_BITS-1], b.y} - {o.y[chul_pkg::COORD_BITS-1], o.y};

  always_ff @(posedge clk) begin
    p1_r <= dax * dby;
    p2_r <= day * dbx;
  end

  assign diff = {p1_r[PW-1], p1_r} - {p2_r[PW-1], p2_r};
  assign not_left = diff[PW] || (diff == '0);

endmodule

// ===== rtl/core/convex_hull_monotone_chain_unit.sv =====
// Convex hull of a point set, monotone chain method. A point is taken when start is high
// and busy low; each point is inserted into a sorted point memory on arrival, moving every
// entry that sorts after it up by one place. The point carrying last_point starts the hull
// pass, which works through both chains one read at a time on the single read port of the
// point and stack memories. Vertices then leave one at a time, each on out_vertex for one
// cycle with out_valid high; the receiver cannot stall them. A set of one point gives no
// vertex. Points beyond capacity are dropped and flagged on every vertex of the run.
// depends on chul_pkg, chul_ram, chul_cross
module convex_hull_monotone_chain_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  chul_pkg::in_t  in_point,
  output logic           out_valid,
  output chul_pkg::out_t out_vertex
);

  localparam int IW = chul_pkg::IDX_W;
  localparam int CW = chul_pkg::CNT_W;
  localparam int SW = chul_pkg::STK_AW;
  localparam int TW = chul_pkg::TOP_W;

  chul_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt, j_r, j_nxt;
  logic          ovf_r, ovf_nxt, last_r, last_nxt, upper_r, upper_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [TW-1:0] top_r, top_nxt, base_r, base_nxt, k_r, k_nxt, total_r, total_nxt;
  chul_pkg::point_t key_r, key_nxt, pa_r, pa_nxt, po_r, po_nxt, pb_r, pb_nxt;
  logic          out_valid_r, out_valid_nxt;
  chul_pkg::out_t out_r, out_nxt;

  logic          pw_en;
  logic [IW-1:0] pw_addr, pr_addr;
  chul_pkg::point_t pw_data, pr_data;
  logic          sw_en;
  logic [SW-1:0] sw_addr, sr_addr;
  logic [IW-1:0] sw_data, sr_data;
  logic          not_left;
  chul_pkg::point_t in_pt;
  logic [TW-1:0] top_dn;
  logic [CW-1:0] n_last;

  chul_ram #(.WIDTH(chul_pkg::PT_W), .DEPTH(chul_pkg::MAX_POINTS)) u_pts (
    .clk(clk), .we(pw_en), .waddr(pw_addr), .wdata(pw_data),
    .raddr(pr_addr), .rdata(pr_data)
  );

  chul_ram #(.WIDTH(IW), .DEPTH(chul_pkg::STK_DEPTH)) u_stk (
    .clk(clk), .we(sw_en), .waddr(sw_addr), .wdata(sw_data),
    .raddr(sr_addr), .rdata(sr_data)
  );

  chul_cross u_cross (.clk(clk), .o(po_r), .a(pa_r), .b(pb_r), .not_left(not_left));

  assign in_pt.x = in_point.point_x;
  assign in_pt.y = in_point.point_y;
  assign top_dn = top_r - TW'(1);
  assign n_last = count_r - CW'(1);
  assign busy = (state_r != chul_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_vertex = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= chul_pkg::S_IDLE;
      count_r <= '0;
      ovf_r <= 1'b0;
      out_valid_r <= 1'b0;
      top_r <= '0;
      base_r <= '0;
      upper_r <= 1'b0;
      k_r <= '0;
      total_r <= '0;
      i_r <= '0;
      j_r <= '0;
      last_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      top_r <= top_nxt;
      base_r <= base_nxt;
      upper_r <= upper_nxt;
      k_r <= k_nxt;
      total_r <= total_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    pa_r <= pa_nxt;
    po_r <= po_nxt;
    pb_r <= pb_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt = ovf_r;
    top_nxt = top_r;
    base_nxt = base_r;
    upper_nxt = upper_r;
    k_nxt = k_r;
    total_nxt = total_r;
    i_nxt = i_r;
    j_nxt = j_r;
    last_nxt = last_r;
    key_nxt = key_r;
    pa_nxt = pa_r;
    po_nxt = po_r;
    pb_nxt = pb_r;
    out_nxt = out_r;
    out_valid_nxt = 1'b0;
    pw_en = 1'b0;
    pw_addr = j_r[IW-1:0];
    pw_data = key_r;
    pr_addr = '0;
    sw_en = 1'b0;
    sw_addr = top_r[SW-1:0];
    sw_data = i_r;
    sr_addr = '0;

    case (state_r)
      chul_pkg::S_IDLE: begin
        if (start) begin
          key_nxt = in_pt;
          last_nxt = in_point.last_point;
          j_nxt = count_r;
          if (count_r == CW'(chul_pkg::MAX_POINTS)) begin
            ovf_nxt = 1'b1;
            if (in_point.last_point) begin
              state_nxt = chul_pkg::S_H_RD;
              top_nxt = '0;
              base_nxt = '0;
              upper_nxt = 1'b0;
              i_nxt = '0;
            end
          end else if (count_r == '0) begin
            pw_en = 1'b1;
            pw_addr = '0;
            pw_data = in_pt;
            count_nxt = CW'(1);
            if (in_point.last_point) begin
              state_nxt = chul_pkg::S_H_RD;
              top_nxt = '0;
              base_nxt = '0;
              upper_nxt = 1'b0;
              i_nxt = '0;
            end
          end else begin
            pr_addr = n_last[IW-1:0];
            state_nxt = chul_pkg::S_INS_CMP;
          end
        end
      end

      chul_pkg::S_INS_CMP: begin
        pw_en = 1'b1;
        pw_addr = j_r[IW-1:0];
        if (chul_pkg::precedes(key_r, pr_data)) begin
          pw_data = pr_data;
          j_nxt = j_r - CW'(1);
          if (j_r == CW'(1)) begin
            state_nxt = chul_pkg::S_INS_PUT;
          end else begin
            pr_addr = IW'(j_r - CW'(2));
          end
        end else begin
          pw_data = key_r;
          count_nxt = count_r + CW'(1);
          state_nxt = last_r ? chul_pkg::S_H_RD : chul_pkg::S_IDLE;
          top_nxt = '0;
          base_nxt = '0;
          upper_nxt = 1'b0;
          i_nxt = '0;
        end
      end

      chul_pkg::S_INS_PUT: begin
        pw_en = 1'b1;
        pw_addr = '0;
        pw_data = key_r;
        count_nxt = count_r + CW'(1);
        state_nxt = last_r ? chul_pkg::S_H_RD : chul_pkg::S_IDLE;
        top_nxt = '0;
        base_nxt = '0;
        upper_nxt = 1'b0;
        i_nxt = '0;
      end

      chul_pkg::S_H_RD: begin
        pr_addr = i_r;
        state_nxt = chul_pkg::S_H_RDB;
      end

      chul_pkg::S_H_RDB: begin
        pb_nxt = pr_data;
        state_nxt = chul_pkg::S_H_CHK;
      end

      chul_pkg::S_H_CHK, chul_pkg::S_H_CMP: begin
        if (state_r == chul_pkg::S_H_CHK && (top_r - base_r) >= TW'(2)) begin
          state_nxt = chul_pkg::S_H_MUL;
        end else if (state_r == chul_pkg::S_H_CMP && not_left) begin
          // pop the top of the chain
          top_nxt = top_dn;
          pa_nxt = po_r;
          if ((top_dn - base_r) >= TW'(2)) begin
            sr_addr = SW'(top_r - TW'(3));
            state_nxt = chul_pkg::S_H_RDS;
          end else begin
            state_nxt = chul_pkg::S_H_CHK;
          end
        end else begin
          // push the new point
          sw_en = 1'b1;
          sw_addr = top_r[SW-1:0];
          sw_data = i_r;
          po_nxt = pa_r;
          pa_nxt = pb_r;
          if (!upper_r) begin
            if ({1'b0, i_r} == n_last) begin
              top_nxt = top_r;
              base_nxt = top_r;
              upper_nxt = 1'b1;
            end else begin
              top_nxt = top_r + TW'(1);
              i_nxt = i_r + IW'(1);
            end
            state_nxt = chul_pkg::S_H_RD;
          end else if (i_r == '0) begin
            top_nxt = top_r;
            total_nxt = top_r;
            k_nxt = '0;
            if (top_r == '0) begin
              count_nxt = '0;
              ovf_nxt = 1'b0;
              state_nxt = chul_pkg::S_IDLE;
            end else begin
              state_nxt = chul_pkg::S_E_RS;
            end
          end else begin
            top_nxt = top_r + TW'(1);
            i_nxt = i_r - IW'(1);
            state_nxt = chul_pkg::S_H_RD;
          end
        end
      end

      chul_pkg::S_H_MUL: begin
        state_nxt = chul_pkg::S_H_CMP;
      end

      chul_pkg::S_H_RDS: begin
        pr_addr = sr_data;
        state_nxt = chul_pkg::S_H_RDO;
      end

      chul_pkg::S_H_RDO: begin
        po_nxt = pr_data;
        state_nxt = chul_pkg::S_H_CHK;
      end

      chul_pkg::S_E_RS: begin
        sr_addr = k_r[SW-1:0];
        state_nxt = chul_pkg::S_E_RP;
      end

      chul_pkg::S_E_RP: begin
        pr_addr = sr_data;
        state_nxt = chul_pkg::S_E_OUT;
      end

      chul_pkg::S_E_OUT: begin
        out_valid_nxt = 1'b1;
        out_nxt.hull_x = pr_data.x;
        out_nxt.hull_y = pr_data.y;
        out_nxt.is_last = ((k_r + TW'(1)) == total_r);
        out_nxt.vertex_count = total_r[5:0];
        out_nxt.points_dropped = ovf_r;
        k_nxt = k_r + TW'(1);
        if ((k_r + TW'(1)) == total_r) begin
          count_nxt = '0;
          ovf_nxt = 1'b0;
          state_nxt = chul_pkg::S_IDLE;
        end else begin
          state_nxt = chul_pkg::S_E_RS;
        end
      end

      default: begin
        state_nxt = chul_pkg::S_IDLE;
      end
    endcase
  end

endmodule
